// ===== hdl/address_stride_detector_core_assert.svh =====
// Assertion macros shared by the stride detector RTL.
`ifndef ADDRESS_STRIDE_DETECTOR_CORE_ASSERT_SVH
`define ADDRESS_STRIDE_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define ASD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define ASD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/asd_pkg.sv =====
`default_nettype none

package asd_pkg;

    // Address width and the width of the bit counter of the serial remainder unit.
    localparam int ADDR_W = 64;
    localparam int CNT_W  = $clog2(ADDR_W);

    // Confidence level codes.
    localparam logic [2:0] LVL_START  = 3'd0;
    localparam logic [2:0] LVL_FIRST  = 3'd1;
    localparam logic [2:0] LVL_LEARN  = 3'd2;
    localparam logic [2:0] LVL_WEAK   = 3'd3;
    localparam logic [2:0] LVL_STRONG = 3'd4;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CMP_HI = 7'b0000010,
        ST_CMP_LO = 7'b0000100,
        ST_SUB    = 7'b0001000,
        ST_ABS    = 7'b0010000,
        ST_DIV    = 7'b0100000,
        ST_FINISH = 7'b1000000
    } ctrl_state_t;

    // Status returned by the serial remainder unit.
    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } div_status_t;

endpackage

`default_nettype wire

// ===== hdl/asd_rem_serial.sv =====
`default_nettype none

// Restoring remainder unit: one dividend bit shifts in per cycle while busy,
// through all ADDR_W bits. The divisor must hold steady while busy.
module asd_rem_serial
    import asd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [ADDR_W-1:0] dividend,
    input  wire logic [ADDR_W-1:0] divisor,
    output div_status_t            status
);

    logic [ADDR_W-1:0] rem_reg;
    logic [ADDR_W-1:0] rem_next;
    logic [ADDR_W-1:0] dvd_reg;
    logic [ADDR_W-1:0] dvd_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic [ADDR_W:0]   trial;
    logic [ADDR_W:0]   diff;
    logic              last;

    // One restoring step: shift in the next dividend bit and subtract if it fits.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[ADDR_W-1]};
        diff  = trial - {1'b0, divisor};
        last  = (cnt_reg == CNT_W'(ADDR_W - 1));
    end

    // Next-state logic for the shift registers and the bit counter.
    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = diff[ADDR_W] ? trial[ADDR_W-1:0] : diff[ADDR_W-1:0];
            dvd_next = {dvd_reg[ADDR_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Data shift registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    // The final remainder appears at the edge where done is high.
    always_comb
    begin
        status.busy     = busy_reg;
        status.done     = busy_reg & last;
        status.rem_zero = (rem_reg == '0);
    end

endmodule

`default_nettype wire

// ===== hdl/address_stride_detector_core.sv =====
`default_nettype none
`include "address_stride_detector_core_assert.svh"

// Stride detector: each accepted address produces one stride_hit transaction,
// which is high while the confidence level is weak or strong (a miss in those
// levels reports low). One address is processed at a time: bound compares and
// distance calculation (ST_CMP_HI to ST_ABS), the bit-serial remainder unit
// (ST_DIV) that tests the distance from the range base against the learned
// stride, an update state (ST_FINISH) that waits while the output stalls, and
// the idle state. A finished result sits in an output register, so the next
// address can be taken while that result is still stalled.
module address_stride_detector_core
    import asd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire logic [ADDR_W-1:0] address,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output logic                   stride_hit
);

    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    logic [2:0]        level_reg;
    logic [2:0]        level_next;
    logic [ADDR_W-1:0] low_reg;
    logic [ADDR_W-1:0] low_next;
    logic [ADDR_W-1:0] high_reg;
    logic [ADDR_W-1:0] high_next;
    logic [ADDR_W-1:0] step_reg;
    logic [ADDR_W-1:0] step_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] diff_reg;
    logic              a_gt_hib_reg;
    logic              a_lt_lob_reg;
    logic              a_gt_high_reg;
    logic              a_lt_low_reg;
    logic              step_zero_reg;
    logic              dist_zero_reg;
    logic              result_valid_reg;
    logic              result_valid_next;
    logic              stride_hit_reg;
    logic              stride_hit_next;

    logic [ADDR_W-1:0] hi_bound;
    logic [ADDR_W-1:0] lo_bound;
    logic [ADDR_W:0]   sub_full;
    logic [ADDR_W-1:0] abs_dist;
    logic [ADDR_W-1:0] wide_low;
    logic [ADDR_W-1:0] wide_high;
    logic              fit;
    logic              out_free;
    logic              div_start;
    div_status_t       div_status;

    // Serial remainder of the distance by the learned stride.
    asd_rem_serial u_rem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (abs_dist),
        .divisor  (step_reg),
        .status   (div_status)
    );

    // Bound and distance arithmetic, one wide operation per sequencer state.
    always_comb
    begin
        hi_bound  = high_reg + step_reg;
        lo_bound  = low_reg - step_reg;
        sub_full  = {1'b0, addr_reg} - {1'b0, low_reg};
        abs_dist  = a_lt_low_reg ? (~diff_reg + 1'b1) : diff_reg;
        div_start = (state_reg == ST_ABS);
    end

    // Fit test and widened range.
    always_comb
    begin
        fit       = !a_gt_hib_reg && !a_lt_lob_reg &&
                    (step_zero_reg ? dist_zero_reg : div_status.rem_zero);
        wide_low  = a_lt_low_reg ? addr_reg : low_reg;
        wide_high = a_gt_high_reg ? addr_reg : high_reg;
        out_free  = !result_valid_reg || !result_stall;
    end

    // Sequencer and level update.
    always_comb
    begin
        state_next        = state_reg;
        level_next        = level_reg;
        low_next          = low_reg;
        high_next         = high_reg;
        step_next         = step_reg;
        stride_hit_next   = stride_hit_reg;
        result_valid_next = result_valid_reg && result_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_CMP_HI;
                end
            end
            ST_CMP_HI: state_next = ST_CMP_LO;
            ST_CMP_LO: state_next = ST_SUB;
            ST_SUB:    state_next = ST_ABS;
            ST_ABS:    state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next        = ST_IDLE;
                    result_valid_next = 1'b1;
                    case (level_reg)
                        LVL_START:
                        begin
                            low_next   = addr_reg;
                            high_next  = addr_reg;
                            level_next = LVL_FIRST;
                        end
                        LVL_FIRST:
                        begin
                            low_next   = wide_low;
                            high_next  = wide_high;
                            step_next  = wide_high - wide_low;
                            level_next = LVL_LEARN;
                        end
                        LVL_LEARN:
                        begin
                            if (step_zero_reg)
                            begin
                                // A repeat of the base address changes nothing.
                                if (!dist_zero_reg)
                                begin
                                    low_next   = addr_reg;
                                    high_next  = addr_reg;
                                    level_next = LVL_FIRST;
                                end
                            end
                            else if (fit)
                            begin
                                low_next   = wide_low;
                                high_next  = wide_high;
                                level_next = LVL_WEAK;
                            end
                            else
                            begin
                                low_next   = addr_reg;
                                high_next  = addr_reg;
                                level_next = LVL_FIRST;
                            end
                        end
                        default:
                        begin
                            if (fit)
                            begin
                                low_next   = wide_low;
                                high_next  = wide_high;
                                level_next = LVL_STRONG;
                            end
                            else
                            begin
                                level_next = (level_reg == LVL_WEAK) ? LVL_LEARN : LVL_WEAK;
                            end
                        end
                    endcase
                    // A miss in the weak or strong level always reports low.
                    if (level_reg != LVL_START && level_reg != LVL_FIRST &&
                        level_reg != LVL_LEARN && !fit)
                    begin
                        stride_hit_next = 1'b0;
                    end
                    else
                    begin
                        stride_hit_next = (level_next == LVL_WEAK) ||
                                          (level_next == LVL_STRONG);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and architectural state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            level_reg        <= LVL_START;
            low_reg          <= '0;
            high_reg         <= '0;
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            level_reg        <= level_next;
            low_reg          <= low_next;
            high_reg         <= high_next;
            step_reg         <= step_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Working registers filled step by step through the sequence.
    always_ff @(posedge clk)
    begin
        stride_hit_reg <= stride_hit_next;
        if (state_reg == ST_IDLE && item_valid)
        begin
            addr_reg <= address;
        end
        if (state_reg == ST_CMP_HI)
        begin
            a_gt_hib_reg <= (addr_reg > hi_bound);
        end
        if (state_reg == ST_CMP_LO)
        begin
            a_lt_lob_reg  <= (addr_reg < lo_bound);
            a_gt_high_reg <= (addr_reg > high_reg);
            step_zero_reg <= (step_reg == '0);
        end
        if (state_reg == ST_SUB)
        begin
            diff_reg     <= sub_full[ADDR_W-1:0];
            a_lt_low_reg <= sub_full[ADDR_W];
        end
        if (state_reg == ST_ABS)
        begin
            dist_zero_reg <= (abs_dist == '0);
        end
    end

    // Port drivers.
    always_comb
    begin
        item_stall   = (state_reg != ST_IDLE);
        result_valid = result_valid_reg;
        stride_hit   = stride_hit_reg;
    end

    // An accepted address starts the compare sequence.
    `ASD_ASSERT_NEXT(a_accept_starts, clk, rst_n, item_valid && !item_stall, state_reg == ST_CMP_HI, "accepted address did not start the sequence")
    // The remainder unit finishes only while the sequencer waits for it.
    `ASD_ASSERT_IMPLY(a_done_in_div, clk, rst_n, div_status.done, state_reg == ST_DIV, "remainder finished outside the divide state")
    // A new result appears only after the update cycle.
    `ASD_ASSERT_IMPLY(a_result_from_finish, clk, rst_n, $rose(result_valid), $past(state_reg == ST_FINISH), "result raised without an update")
    // The confidence level never takes an unused code.
    `ASD_ASSERT_IMPLY(a_level_range, clk, rst_n, 1'b1, level_reg <= LVL_STRONG, "confidence level out of range")

endmodule

`default_nettype wire
